// ----- hdl/eight_bit_cpu_execute_core_top_defines.svh -----
// assertion macros for the execute core
`ifndef EIGHT_BIT_CPU_EXECUTE_CORE_TOP_DEFINES_SVH
`define EIGHT_BIT_CPU_EXECUTE_CORE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define EBCPU_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ebcpu: same-cycle check failed");
`define EBCPU_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ebcpu: next-cycle check failed");
`else
`define EBCPU_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define EBCPU_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// ----- hdl/ebcpu_pkg.sv -----
package ebcpu_pkg;

	localparam logic [3:0] PH_OP  = 4'd0;
	localparam logic [3:0] PH_IM1 = 4'd1;
	localparam logic [3:0] PH_IM2 = 4'd2;
	localparam logic [3:0] PH_MEM = 4'd3;
	localparam logic [3:0] PH_SL  = 4'd4;
	localparam logic [3:0] PH_SH  = 4'd5;

	localparam logic [63:0] REGS_RESET = 64'h4D01_D800_1300_B001;
	localparam logic [15:0] SP_RESET   = 16'hFFFE;
	localparam logic [15:0] PC_RESET   = 16'h0100;
	localparam logic [15:0] IO_PAGE    = 16'hFF00;

	typedef logic [7:0][7:0] regs_t;

	typedef struct packed {
		regs_t       r;
		logic [15:0] sp;
		logic [15:0] pc;
		logic        ime;
		logic        halt;
		logic [3:0]  phase;
		logic [7:0]  opl;
		logic [7:0]  opr;
	} st_t;

	typedef struct packed {
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
	} res_t;

	typedef struct packed {
		res_t [2:0]  res;
		logic [1:0]  n;
		logic [4:0]  ack;
		logic        halt;
	} step_t;

	function automatic logic [2:0] ridx(input logic [2:0] r);
		logic [2:0] x;
		case (r)
			3'd6, 3'd7: x = 3'd0;
			default:    x = r + 3'd2;
		endcase
		return x;
	endfunction

	function automatic logic cond(input logic [7:0] op, input logic [7:0] f);
		logic c;
		case (op[4:3])
			2'd0:    c = !f[7];
			2'd1:    c = f[7];
			2'd2:    c = !f[4];
			default: c = f[4];
		endcase
		return c;
	endfunction

	function automatic logic is_imm16(input logic [7:0] op);
		return ((op & 8'hCF) == 8'h01) || (op == 8'h08) || ((op & 8'hE7) == 8'hC2) ||
			((op & 8'hE7) == 8'hC4) || (op == 8'hC3) || (op == 8'hCD) ||
			(op == 8'hEA) || (op == 8'hFA);
	endfunction

	function automatic logic [15:0] get_rr(input regs_t r, input logic [15:0] sp,
			input logic [1:0] p);
		logic [15:0] v;
		case (p)
			2'd0:    v = {r[2], r[3]};
			2'd1:    v = {r[4], r[5]};
			2'd2:    v = {r[6], r[7]};
			default: v = sp;
		endcase
		return v;
	endfunction

	// returns {flags, result}
	function automatic logic [15:0] alu8(input logic [2:0] op, input logic [7:0] a,
			input logic [7:0] f, input logic [7:0] v);
		logic       c;
		logic [8:0] w;
		logic [4:0] hn;
		logic [7:0] r;
		logic [7:0] nf;
		c  = f[4] & ((op == 3'd1) || (op == 3'd3));
		w  = 9'd0;
		hn = 5'd0;
		nf = 8'h00;
		case (op)
			3'd0, 3'd1: begin
				w  = {1'b0, a} + {1'b0, v} + {8'd0, c};
				hn = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
				r  = w[7:0];
				nf = {2'b00, hn[4], w[8], 4'h0};
			end
			3'd2, 3'd3, 3'd7: begin
				w  = {1'b0, v} + {8'd0, c};
				hn = {1'b0, v[3:0]} + {4'd0, c};
				r  = a - v - {7'd0, c};
				nf = {2'b01, ({1'b0, a[3:0]} < hn), ({1'b0, a} < w), 4'h0};
			end
			3'd4: begin
				r  = a & v;
				nf = 8'h20;
			end
			3'd5:    r = a ^ v;
			default: r = a | v;
		endcase
		nf[7] = (r == 8'h00);
		return {nf, r};
	endfunction

	function automatic logic [15:0] inc8(input logic [7:0] v, input logic [7:0] f);
		logic [7:0] r;
		r = v + 8'd1;
		return {(r == 8'h00), 1'b0, (r[3:0] == 4'h0), f[4], 4'h0, r};
	endfunction

	function automatic logic [15:0] dec8(input logic [7:0] v, input logic [7:0] f);
		logic [7:0] r;
		r = v - 8'd1;
		return {(r == 8'h00), 1'b1, (r[3:0] == 4'hF), f[4], 4'h0, r};
	endfunction

	// returns {flags, sum}
	function automatic logic [23:0] sp_off(input logic [15:0] sp, input logic [7:0] b);
		logic [4:0] h;
		logic [8:0] c;
		h = {1'b0, sp[3:0]} + {1'b0, b[3:0]};
		c = {1'b0, sp[7:0]} + {1'b0, b};
		return {2'b00, h[4], c[8], 4'h0, sp + {{8{b[7]}}, b}};
	endfunction

endpackage

// ----- hdl/ebcpu_exec.sv -----
module ebcpu_exec (
	input  ebcpu_pkg::st_t   st,
	input  logic             action,
	input  logic [7:0]       b,
	input  logic [4:0]       pend,
	output ebcpu_pkg::st_t   nxt,
	output ebcpu_pkg::step_t step
);

	always_comb begin
		ebcpu_pkg::st_t          s;
		ebcpu_pkg::res_t [2:0]   res;
		logic [1:0]  n;
		logic [4:0]  ack;
		logic        fe;
		logic [7:0]  o;
		logic [2:0]  z;
		logic [2:0]  y;
		logic [1:0]  p;
		logic [2:0]  iv;
		logic [15:0] hl;
		logic [15:0] t;
		logic [15:0] ad;
		logic [16:0] s17;
		logic [12:0] s13;
		logic [23:0] so;
		logic [7:0]  v;
		logic [7:0]  a;
		logic        cr;

		s   = st;
		res = '0;
		n   = 2'd0;
		ack = 5'd0;
		fe  = 1'b0;
		o   = (st.phase == ebcpu_pkg::PH_OP) ? b : st.opl;
		z   = o[2:0];
		y   = o[5:3];
		p   = o[5:4];
		iv  = 3'd0;
		hl  = {st.r[6], st.r[7]};
		t   = 16'd0;
		ad  = 16'd0;
		s17 = 17'd0;
		s13 = 13'd0;
		so  = 24'd0;
		v   = 8'd0;
		a   = st.r[0];
		cr  = 1'b0;

		if (action) begin
			if (st.phase == ebcpu_pkg::PH_OP)
				fe = 1'b1;
		end else begin
			case (st.phase)
				ebcpu_pkg::PH_OP: begin
					if (st.ime && pend != 5'd0) begin
						if (pend[0])      iv = 3'd0;
						else if (pend[1]) iv = 3'd1;
						else if (pend[2]) iv = 3'd2;
						else if (pend[3]) iv = 3'd3;
						else              iv = 3'd4;
						ack    = 5'd1 << iv;
						s.ime  = 1'b0;
						s.halt = 1'b0;
						s.sp   = s.sp - 16'd1;
						res[n] = '{1'b1, s.sp, s.pc[15:8]}; n = n + 2'd1;
						s.sp   = s.sp - 16'd1;
						res[n] = '{1'b1, s.sp, s.pc[7:0]}; n = n + 2'd1;
						s.pc   = 16'h0040 + {10'd0, iv, 3'd0};
						fe     = 1'b1;
					end else if (st.halt && pend == 5'd0) begin
						fe = 1'b1;
					end else begin
						s.halt = 1'b0;
						s.opl  = o;
						s.pc   = s.pc + 16'd1;
						if (o[7:6] == 2'b01 || o[7:6] == 2'b10) begin
							if (o == 8'h76) begin
								s.halt = 1'b1;
								fe     = 1'b1;
							end else if (z == 3'd6) begin
								res[n] = '{1'b0, hl, 8'h00}; n = n + 2'd1;
								s.phase = ebcpu_pkg::PH_MEM;
							end else begin
								v = s.r[ebcpu_pkg::ridx(z)];
								if (o[7:6] == 2'b01) begin
									if (y == 3'd6) begin
										res[n] = '{1'b1, hl, v}; n = n + 2'd1;
									end else
										s.r[ebcpu_pkg::ridx(y)] = v;
								end else begin
									t = ebcpu_pkg::alu8(y, s.r[0], s.r[1], v);
									s.r[1] = t[15:8];
									if (y != 3'd7)
										s.r[0] = t[7:0];
								end
								fe = 1'b1;
							end
						end else if (o[7:6] == 2'b00) begin
							case (z)
								3'd0: begin
									if (y == 3'd1 || y >= 3'd3) begin
										res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
										s.pc = s.pc + 16'd1;
										s.phase = ebcpu_pkg::PH_IM1;
									end else
										fe = 1'b1;
								end
								3'd1: begin
									if (!y[0]) begin
										res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
										s.pc = s.pc + 16'd1;
										s.phase = ebcpu_pkg::PH_IM1;
									end else begin
										t   = ebcpu_pkg::get_rr(s.r, s.sp, p);
										s17 = {1'b0, hl} + {1'b0, t};
										s13 = {1'b0, hl[11:0]} + {1'b0, t[11:0]};
										s.r[1] = {s.r[1][7], 1'b0, s13[12], s17[16], 4'h0};
										{s.r[6], s.r[7]} = s17[15:0];
										fe = 1'b1;
									end
								end
								3'd2: begin
									case (p)
										2'd0:    ad = {s.r[2], s.r[3]};
										2'd1:    ad = {s.r[4], s.r[5]};
										default: ad = hl;
									endcase
									if (y[0]) begin
										res[n] = '{1'b0, ad, 8'h00}; n = n + 2'd1;
										s.phase = ebcpu_pkg::PH_MEM;
									end else begin
										res[n] = '{1'b1, ad, s.r[0]}; n = n + 2'd1;
										if (p == 2'd2) {s.r[6], s.r[7]} = hl + 16'd1;
										if (p == 2'd3) {s.r[6], s.r[7]} = hl - 16'd1;
										fe = 1'b1;
									end
								end
								3'd3: begin
									t = ebcpu_pkg::get_rr(s.r, s.sp, p);
									t = y[0] ? t - 16'd1 : t + 16'd1;
									case (p)
										2'd0:    {s.r[2], s.r[3]} = t;
										2'd1:    {s.r[4], s.r[5]} = t;
										2'd2:    {s.r[6], s.r[7]} = t;
										default: s.sp = t;
									endcase
									fe = 1'b1;
								end
								3'd4, 3'd5: begin
									if (y == 3'd6) begin
										res[n] = '{1'b0, hl, 8'h00}; n = n + 2'd1;
										s.phase = ebcpu_pkg::PH_MEM;
									end else begin
										v = s.r[ebcpu_pkg::ridx(y)];
										t = (z == 3'd4) ? ebcpu_pkg::inc8(v, s.r[1]) :
											ebcpu_pkg::dec8(v, s.r[1]);
										s.r[1] = t[15:8];
										s.r[ebcpu_pkg::ridx(y)] = t[7:0];
										fe = 1'b1;
									end
								end
								3'd6: begin
									res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
									s.pc = s.pc + 16'd1;
									s.phase = ebcpu_pkg::PH_IM1;
								end
								default: begin
									if (y <= 3'd3) begin
										case (y)
											3'd0: begin cr = a[7]; a = {a[6:0], a[7]}; end
											3'd1: begin cr = a[0]; a = {a[0], a[7:1]}; end
											3'd2: begin cr = a[7]; a = {a[6:0], s.r[1][4]}; end
											default: begin cr = a[0]; a = {s.r[1][4], a[7:1]}; end
										endcase
										s.r[0] = a;
										s.r[1] = {3'b000, cr, 4'h0};
									end
									fe = 1'b1;
								end
							endcase
						end else begin
							case (z)
								3'd0: begin
									if (y >= 3'd4) begin
										res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
										s.pc = s.pc + 16'd1;
										s.phase = ebcpu_pkg::PH_IM1;
									end else if (ebcpu_pkg::cond(o, s.r[1])) begin
										res[n] = '{1'b0, s.sp, 8'h00}; n = n + 2'd1;
										s.phase = ebcpu_pkg::PH_SL;
									end else
										fe = 1'b1;
								end
								3'd1: begin
									if (!y[0] || p <= 2'd1) begin
										res[n] = '{1'b0, s.sp, 8'h00}; n = n + 2'd1;
										s.phase = ebcpu_pkg::PH_SL;
									end else begin
										if (p == 2'd2) s.pc = hl;
										else           s.sp = hl;
										fe = 1'b1;
									end
								end
								3'd2: begin
									if (y == 3'd4) begin
										res[n] = '{1'b1, ebcpu_pkg::IO_PAGE | {8'h00, s.r[3]}, s.r[0]};
										n = n + 2'd1;
										fe = 1'b1;
									end else if (y == 3'd6) begin
										res[n] = '{1'b0, ebcpu_pkg::IO_PAGE | {8'h00, s.r[3]}, 8'h00};
										n = n + 2'd1;
										s.phase = ebcpu_pkg::PH_MEM;
									end else begin
										res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
										s.pc = s.pc + 16'd1;
										s.phase = ebcpu_pkg::PH_IM1;
									end
								end
								3'd3: begin
									if (y == 3'd0) begin
										res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
										s.pc = s.pc + 16'd1;
										s.phase = ebcpu_pkg::PH_IM1;
									end else begin
										if (y == 3'd6) s.ime = 1'b0;
										if (y == 3'd7) s.ime = 1'b1;
										fe = 1'b1;
									end
								end
								3'd4: begin
									if (y < 3'd4) begin
										res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
										s.pc = s.pc + 16'd1;
										s.phase = ebcpu_pkg::PH_IM1;
									end else
										fe = 1'b1;
								end
								3'd5: begin
									if (!y[0]) begin
										t = (p == 2'd3) ? {s.r[0], s.r[1][7:4], 4'h0} :
											ebcpu_pkg::get_rr(s.r, s.sp, p);
										s.sp   = s.sp - 16'd1;
										res[n] = '{1'b1, s.sp, t[15:8]}; n = n + 2'd1;
										s.sp   = s.sp - 16'd1;
										res[n] = '{1'b1, s.sp, t[7:0]}; n = n + 2'd1;
										fe = 1'b1;
									end else if (p == 2'd0) begin
										res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
										s.pc = s.pc + 16'd1;
										s.phase = ebcpu_pkg::PH_IM1;
									end else
										fe = 1'b1;
								end
								3'd6: begin
									res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
									s.pc = s.pc + 16'd1;
									s.phase = ebcpu_pkg::PH_IM1;
								end
								default: begin
									s.sp   = s.sp - 16'd1;
									res[n] = '{1'b1, s.sp, s.pc[15:8]}; n = n + 2'd1;
									s.sp   = s.sp - 16'd1;
									res[n] = '{1'b1, s.sp, s.pc[7:0]}; n = n + 2'd1;
									s.pc = {10'd0, y, 3'd0};
									fe = 1'b1;
								end
							endcase
						end
					end
				end
				ebcpu_pkg::PH_IM1: begin
					if (ebcpu_pkg::is_imm16(o)) begin
						s.opr  = b;
						res[n] = '{1'b0, s.pc, 8'h00}; n = n + 2'd1;
						s.pc = s.pc + 16'd1;
						s.phase = ebcpu_pkg::PH_IM2;
					end else if (o == 8'hF0) begin
						res[n] = '{1'b0, ebcpu_pkg::IO_PAGE | {8'h00, b}, 8'h00};
						n = n + 2'd1;
						s.phase = ebcpu_pkg::PH_MEM;
					end else begin
						if ((o & 8'hC7) == 8'h06) begin
							if (y == 3'd6) begin
								res[n] = '{1'b1, hl, b}; n = n + 2'd1;
							end else
								s.r[ebcpu_pkg::ridx(y)] = b;
						end else if (o == 8'h18 || (o & 8'hE7) == 8'h20) begin
							if (o == 8'h18 || ebcpu_pkg::cond(o, s.r[1]))
								s.pc = s.pc + {{8{b[7]}}, b};
						end else if ((o & 8'hC7) == 8'hC6) begin
							t = ebcpu_pkg::alu8(y, s.r[0], s.r[1], b);
							s.r[1] = t[15:8];
							if (y != 3'd7)
								s.r[0] = t[7:0];
						end else if (o == 8'hE0) begin
							res[n] = '{1'b1, ebcpu_pkg::IO_PAGE | {8'h00, b}, s.r[0]};
							n = n + 2'd1;
						end else if (o == 8'hE8 || o == 8'hF8) begin
							so = ebcpu_pkg::sp_off(s.sp, b);
							s.r[1] = so[23:16];
							if (o == 8'hE8) s.sp = so[15:0];
							else            {s.r[6], s.r[7]} = so[15:0];
						end
						fe = 1'b1;
					end
				end
				ebcpu_pkg::PH_IM2: begin
					ad = {b, s.opr};
					if (o == 8'hFA) begin
						res[n] = '{1'b0, ad, 8'h00}; n = n + 2'd1;
						s.phase = ebcpu_pkg::PH_MEM;
					end else begin
						if ((o & 8'hCF) == 8'h01) begin
							case (o[5:4])
								2'd0:    {s.r[2], s.r[3]} = ad;
								2'd1:    {s.r[4], s.r[5]} = ad;
								2'd2:    {s.r[6], s.r[7]} = ad;
								default: s.sp = ad;
							endcase
						end else if (o == 8'h08) begin
							res[n] = '{1'b1, ad, s.sp[7:0]}; n = n + 2'd1;
							res[n] = '{1'b1, ad + 16'd1, s.sp[15:8]}; n = n + 2'd1;
						end else if (o == 8'hC3 ||
								((o & 8'hE7) == 8'hC2 && ebcpu_pkg::cond(o, s.r[1]))) begin
							s.pc = ad;
						end else if (o == 8'hCD ||
								((o & 8'hE7) == 8'hC4 && ebcpu_pkg::cond(o, s.r[1]))) begin
							s.sp   = s.sp - 16'd1;
							res[n] = '{1'b1, s.sp, s.pc[15:8]}; n = n + 2'd1;
							s.sp   = s.sp - 16'd1;
							res[n] = '{1'b1, s.sp, s.pc[7:0]}; n = n + 2'd1;
							s.pc = ad;
						end else if (o == 8'hEA) begin
							res[n] = '{1'b1, ad, s.r[0]}; n = n + 2'd1;
						end
						fe = 1'b1;
					end
				end
				ebcpu_pkg::PH_MEM: begin
					if (o[7:6] == 2'b01) begin
						if (y == 3'd6) begin
							res[n] = '{1'b1, hl, b}; n = n + 2'd1;
						end else
							s.r[ebcpu_pkg::ridx(y)] = b;
					end else if (o[7:6] == 2'b10) begin
						t = ebcpu_pkg::alu8(y, s.r[0], s.r[1], b);
						s.r[1] = t[15:8];
						if (y != 3'd7)
							s.r[0] = t[7:0];
					end else if (o == 8'h34 || o == 8'h35) begin
						t = (o == 8'h34) ? ebcpu_pkg::inc8(b, s.r[1]) :
							ebcpu_pkg::dec8(b, s.r[1]);
						s.r[1] = t[15:8];
						res[n] = '{1'b1, hl, t[7:0]}; n = n + 2'd1;
					end else begin
						s.r[0] = b;
						if (o == 8'h2A) {s.r[6], s.r[7]} = hl + 16'd1;
						if (o == 8'h3A) {s.r[6], s.r[7]} = hl - 16'd1;
					end
					fe = 1'b1;
				end
				ebcpu_pkg::PH_SL: begin
					s.opr  = b;
					res[n] = '{1'b0, s.sp + 16'd1, 8'h00}; n = n + 2'd1;
					s.phase = ebcpu_pkg::PH_SH;
				end
				ebcpu_pkg::PH_SH: begin
					ad   = {b, s.opr};
					s.sp = s.sp + 16'd2;
					case (o)
						8'hC1:   {s.r[2], s.r[3]} = ad;
						8'hD1:   {s.r[4], s.r[5]} = ad;
						8'hE1:   {s.r[6], s.r[7]} = ad;
						8'hF1:   {s.r[0], s.r[1]} = {ad[15:4], 4'h0};
						default: begin
							s.pc = ad;
							if (o == 8'hD9) s.ime = 1'b1;
						end
					endcase
					fe = 1'b1;
				end
				default: s.phase = ebcpu_pkg::PH_OP;
			endcase
		end

		if (fe) begin
			res[n]  = '{1'b0, s.pc, 8'h00};
			n       = n + 2'd1;
			s.phase = ebcpu_pkg::PH_OP;
		end

		nxt       = s;
		step.res  = res;
		step.n    = n;
		step.ack  = ack;
		step.halt = s.halt;
	end

endmodule

// ----- hdl/ebcpu_outq.sv -----
module ebcpu_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ebcpu_pkg::step_t step,
	output logic             room,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,
	output logic             m_tuser,
	output logic             m_tlast
);

	ebcpu_pkg::step_t step_q;
	logic [1:0]       cnt_q;
	logic [1:0]       idx_q;
	ebcpu_pkg::res_t  cur;
	logic             pop;

	assign cur      = step_q.res[idx_q];
	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tlast  = (idx_q == cnt_q - 2'd1);
	assign m_tuser  = cur.wr;
	assign m_tdata  = {2'b00, step_q.halt, step_q.ack, cur.data, cur.addr};
	assign pop      = m_tvalid && m_tready;
	assign room     = !m_tvalid || (pop && m_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= step.n;
			idx_q <= 2'd0;
		end else if (pop) begin
			if (m_tlast)
				cnt_q <= 2'd0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			step_q <= step;
	end

endmodule

// ----- hdl/eight_bit_cpu_execute_core_top.sv -----
// Bus sequencer for the unprefixed 8-bit instruction set. Each input item is a start
// pulse (tuser 1) or the byte returned for the last read request (tuser 0); it
// produces up to three bus requests, writes first, a read last, with tlast on the
// final one. An item is executed in the cycle it is accepted and its requests sit in a
// result register, so an item that causes one request is taken every cycle while the
// receiver accepts it; an item that causes two or three holds the input while the result
// register drains. Interrupts are taken at opcode boundaries by fixed priority.
`include "eight_bit_cpu_execute_core_top_defines.svh"
module eight_bit_cpu_execute_core_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // read_data, int_pending
	input  logic        s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // bus_address, write_data, int_ack, halted
	output logic        m_tuser,   // bus_write
	output logic        m_tlast
);

	ebcpu_pkg::st_t   st_q;
	ebcpu_pkg::st_t   nxt;
	ebcpu_pkg::step_t step;
	logic             acc;

	assign acc = s_tvalid && s_tready;

	ebcpu_exec u_exec (
		.st     (st_q),
		.action (s_tuser),
		.b      (s_tdata[7:0]),
		.pend   (s_tdata[12:8]),
		.nxt    (nxt),
		.step   (step)
	);

	ebcpu_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (acc),
		.step     (step),
		.room     (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.r     <= ebcpu_pkg::REGS_RESET;
			st_q.sp    <= ebcpu_pkg::SP_RESET;
			st_q.pc    <= ebcpu_pkg::PC_RESET;
			st_q.ime   <= 1'b0;
			st_q.halt  <= 1'b0;
			st_q.phase <= ebcpu_pkg::PH_OP;
			st_q.opl   <= 8'h00;
			st_q.opr   <= 8'h00;
		end else if (acc) begin
			st_q <= nxt;
		end
	end

	`EBCPU_ASSERT_IMP(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)
	`EBCPU_ASSERT_NXT(a_results_follow, clk, arst_n, acc && step.n != 2'd0, m_tvalid)
	`EBCPU_ASSERT_IMP(a_ack_onehot, clk, arst_n, m_tvalid, $onehot0(m_tdata[28:24]))
	`EBCPU_ASSERT_IMP(a_phase_legal, clk, arst_n, 1'b1, st_q.phase <= ebcpu_pkg::PH_SH)

endmodule

// ----- verif/eight_bit_cpu_execute_core_top_tb.sv -----
module eight_bit_cpu_execute_core_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] FL_Z = 8'h80;
	localparam logic [7:0] FL_N = 8'h40;
	localparam logic [7:0] FL_H = 8'h20;
	localparam logic [7:0] FL_C = 8'h10;

	localparam logic [7:0] OP_NOP      = 8'h00;
	localparam logic [7:0] OP_LD_NN_SP = 8'h08;
	localparam logic [7:0] OP_LD_A_N   = 8'h3E;
	localparam logic [7:0] OP_INC_MHL  = 8'h34;
	localparam logic [7:0] OP_DEC_MHL  = 8'h35;
	localparam logic [7:0] OP_LDI_A    = 8'h2A;
	localparam logic [7:0] OP_HALT     = 8'h76;
	localparam logic [7:0] OP_PUSH_BC  = 8'hC5;
	localparam logic [7:0] OP_POP_AF   = 8'hF1;
	localparam logic [7:0] OP_ADD_A_N  = 8'hC6;
	localparam logic [7:0] OP_RET      = 8'hC9;
	localparam logic [7:0] OP_CALL     = 8'hCD;
	localparam logic [7:0] OP_RETI     = 8'hD9;
	localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
	localparam logic [7:0] OP_ADD_SP_E = 8'hE8;
	localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
	localparam logic [7:0] OP_DI       = 8'hF3;
	localparam logic [7:0] OP_LD_HL_SP = 8'hF8;
	localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
	localparam logic [7:0] OP_EI       = 8'hFB;
	localparam logic [7:0] OP_RST38    = 8'hFF;
	localparam logic ACT_DATA  = 1'b0;
	localparam logic ACT_START = 1'b1;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic        wr;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [4:0]  ack;
		logic        halted;
		logic        last;
	} bus_req_t;

	class cpu_scoreboard;
		logic [7:0]  rg[8];
		logic [15:0] sp, pc;
		logic        ime, hlt;
		logic [3:0]  ph;
		logic [7:0]  opl, opr;
		bus_req_t    step_reqs[$];
		bus_req_t    expected_reqs[$];
		int          errors, reqs_checked, irqs_taken;

		function new();
			for (int i = 0; i < 8; i++) rg[i] = ebcpu_pkg::REGS_RESET[8*i +: 8];
			sp = ebcpu_pkg::SP_RESET;
			pc = ebcpu_pkg::PC_RESET;
			ime = 1'b0;
			hlt = 1'b0;
			ph = ebcpu_pkg::PH_OP;
			opl = 8'h00;
			opr = 8'h00;
		endfunction

		function int unsigned ri(input int unsigned r);
			return (r >= 6) ? 0 : r + 2;
		endfunction

		function void emit(input logic wr, input logic [15:0] addr, input logic [7:0] data);
			bus_req_t q;
			if (step_reqs.size() >= 3) return;
			q = '0;
			q.wr = wr;
			q.addr = addr;
			q.data = data;
			step_reqs.push_back(q);
		endfunction

		function void read_at(input logic [15:0] addr, input logic [3:0] p);
			ph = p;
			emit(1'b0, addr, 8'h00);
		endfunction

		function void fetch();
			read_at(pc, ebcpu_pkg::PH_OP);
		endfunction

		function void read_imm(input logic [3:0] p);
			read_at(pc, p);
			pc = pc + 16'd1;
		endfunction

		function logic [15:0] pair(input int unsigned hi);
			return {rg[hi & 6], rg[(hi & 6) + 1]};
		endfunction

		function void set_pair(input int unsigned hi, input logic [15:0] v);
			rg[hi & 6] = v[15:8];
			rg[(hi & 6) + 1] = v[7:0];
		endfunction

		function logic [15:0] rr_get(input int unsigned c);
			return (c == 3) ? sp : pair(2 + 2 * c);
		endfunction

		function void rr_set(input int unsigned c, input logic [15:0] v);
			if (c == 3) sp = v;
			else set_pair(2 + 2 * c, v);
		endfunction

		function logic cond_met(input logic [7:0] op);
			case (op[4:3])
				2'd0: return !rg[1][7];
				2'd1: return rg[1][7];
				2'd2: return !rg[1][4];
				default: return rg[1][4];
			endcase
		endfunction

		function void push16(input logic [15:0] v);
			sp = sp - 16'd1;
			emit(1'b1, sp, v[15:8]);
			sp = sp - 16'd1;
			emit(1'b1, sp, v[7:0]);
		endfunction

		function void alu(input int unsigned op, input int unsigned v);
			int unsigned a, c, r;
			logic [7:0] f;
			a = rg[0];
			c = rg[1][4];
			f = 8'h00;
			op &= 7;
			if (op == 0 || op == 2 || op == 7) c = 0;
			if (op <= 1) begin
				r = a + v + c;
				if ((a & 15) + (v & 15) + c > 15) f |= FL_H;
				if (r > 255) f |= FL_C;
			end else if (op == 2 || op == 3 || op == 7) begin
				r = a - v - c;
				f = FL_N;
				if ((a & 15) < (v & 15) + c) f |= FL_H;
				if (a < v + c) f |= FL_C;
			end else if (op == 4) begin
				r = a & v;
				f = FL_H;
			end else if (op == 5) r = a ^ v;
			else r = a | v;
			r &= 255;
			if (r == 0) f |= FL_Z;
			rg[1] = f;
			if (op != 7) rg[0] = r[7:0];
		endfunction

		function logic [7:0] inc8(input logic [7:0] v);
			logic [7:0] r;
			r = v + 8'd1;
			rg[1] = (rg[1] & FL_C) | ((r == 8'h00) ? FL_Z : 8'h00) |
				((r[3:0] == 4'h0) ? FL_H : 8'h00);
			return r;
		endfunction

		function logic [7:0] dec8(input logic [7:0] v);
			logic [7:0] r;
			r = v - 8'd1;
			rg[1] = (rg[1] & FL_C) | FL_N | ((r == 8'h00) ? FL_Z : 8'h00) |
				((r[3:0] == 4'hF) ? FL_H : 8'h00);
			return r;
		endfunction

		function logic [15:0] sp_offset(input logic [7:0] b);
			int unsigned s;
			s = sp;
			rg[1] = ((((s & 15) + (b & 15)) > 15) ? FL_H : 8'h00) |
				((((s & 255) + b) > 255) ? FL_C : 8'h00);
			return sp + {{8{b[7]}}, b};
		endfunction

		function void store_reg(input int unsigned r, input logic [7:0] v);
			r &= 7;
			if (r == 6) emit(1'b1, pair(6), v);
			else rg[ri(r)] = v;
		endfunction

		function logic takes_word(input logic [7:0] op);
			return ((op & 8'hCF) == 8'h01) || op == 8'h08 || ((op & 8'hE7) == 8'hC2) ||
				((op & 8'hE7) == 8'hC4) || op == 8'hC3 || op == 8'hCD || op == 8'hEA ||
				op == 8'hFA;
		endfunction

		function void exec_low(input logic [7:0] op);
			int unsigned z, y, p, hl, c, oc, a;
			z = op[2:0];
			y = op[5:3];
			p = y >> 1;
			a = rg[0];
			case (z)
				0: if (y == 1 || y >= 3) begin
					read_imm(ebcpu_pkg::PH_IM1);
					return;
				end
				1: begin
					if (!y[0]) begin
						read_imm(ebcpu_pkg::PH_IM1);
						return;
					end
					hl = pair(6);
					c = rr_get(p);
					rg[1] = (rg[1] & FL_Z) |
						((((hl & 'hFFF) + (c & 'hFFF)) > 'hFFF) ? FL_H : 8'h00) |
						(((hl + c) > 'hFFFF) ? FL_C : 8'h00);
					set_pair(6, 16'(hl + c));
				end
				2: begin
					hl = pair(6);
					c = (p == 0) ? pair(2) : ((p == 1) ? pair(4) : hl);
					if (y[0]) begin
						read_at(16'(c), ebcpu_pkg::PH_MEM);
						return;
					end
					emit(1'b1, 16'(c), 8'(a));
					if (p == 2) set_pair(6, 16'(hl + 1));
					if (p == 3) set_pair(6, 16'(hl - 1));
				end
				3: rr_set(p, y[0] ? rr_get(p) - 16'd1 : rr_get(p) + 16'd1);
				4, 5: begin
					if (y == 6) begin
						read_at(pair(6), ebcpu_pkg::PH_MEM);
						return;
					end
					c = rg[ri(y)];
					rg[ri(y)] = (z == 4) ? inc8(8'(c)) : dec8(8'(c));
				end
				6: begin
					read_imm(ebcpu_pkg::PH_IM1);
					return;
				end
				default: begin
					oc = rg[1][4];
					if (y <= 3) begin
						if (y == 0) begin
							c = a >> 7;
							a = ((a << 1) | c) & 255;
						end else if (y == 1) begin
							c = a & 1;
							a = (a >> 1) | (c << 7);
						end else if (y == 2) begin
							c = a >> 7;
							a = ((a << 1) | oc) & 255;
						end else begin
							c = a & 1;
							a = (a >> 1) | (oc << 7);
						end
						rg[0] = 8'(a);
						rg[1] = (c != 0) ? FL_C : 8'h00;
					end
				end
			endcase
			fetch();
		endfunction

		function void exec_high(input logic [7:0] op);
			int unsigned z, y, p;
			z = op[2:0];
			y = op[5:3];
			p = y >> 1;
			case (z)
				0: if (y >= 4) begin
					read_imm(ebcpu_pkg::PH_IM1);
					return;
				end else if (cond_met(op)) begin
					read_at(sp, ebcpu_pkg::PH_SL);
					return;
				end
				1: begin
					if (!y[0] || p <= 1) begin
						read_at(sp, ebcpu_pkg::PH_SL);
						return;
					end
					if (p == 2) pc = pair(6);
					else sp = pair(6);
				end
				2: begin
					if (y == 4) emit(1'b1, ebcpu_pkg::IO_PAGE | {8'h00, rg[3]}, rg[0]);
					else if (y == 6) begin
						read_at(ebcpu_pkg::IO_PAGE | {8'h00, rg[3]}, ebcpu_pkg::PH_MEM);
						return;
					end else begin
						read_imm(ebcpu_pkg::PH_IM1);
						return;
					end
				end
				3: begin
					if (y == 0) begin
						read_imm(ebcpu_pkg::PH_IM1);
						return;
					end
					if (y == 6) ime = 1'b0;
					if (y == 7) ime = 1'b1;
				end
				4: if (y < 4) begin
					read_imm(ebcpu_pkg::PH_IM1);
					return;
				end
				5: begin
					if (!y[0]) push16((p == 3) ? (pair(0) & 16'hFFF0) : pair(2 + 2 * p));
					else if (p == 0) begin
						read_imm(ebcpu_pkg::PH_IM1);
						return;
					end
				end
				6: begin
					read_imm(ebcpu_pkg::PH_IM1);
					return;
				end
				default: begin
					push16(pc);
					pc = 16'(y * 8);
				end
			endcase
			fetch();
		endfunction

		function void exec_opcode(input logic [7:0] op);
			opl = op;
			pc = pc + 16'd1;
			if (op >= 8'h40 && op < 8'hC0) begin
				if (op == OP_HALT) begin
					hlt = 1'b1;
					fetch();
					return;
				end
				if (op[2:0] == 3'd6) begin
					read_at(pair(6), ebcpu_pkg::PH_MEM);
					return;
				end
				if (op < 8'h80) store_reg(op[5:3], rg[ri(op[2:0])]);
				else alu(op[5:3], rg[ri(op[2:0])]);
				fetch();
			end else if (op < 8'h40) exec_low(op);
			else exec_high(op);
		endfunction

		function void after_imm1(input logic [7:0] op, input logic [7:0] b);
			if (takes_word(op)) begin
				opr = b;
				read_imm(ebcpu_pkg::PH_IM2);
				return;
			end
			if ((op & 8'hC7) == 8'h06) store_reg(op[5:3], b);
			else if (op == 8'h18 || (op & 8'hE7) == 8'h20) begin
				if (op == 8'h18 || cond_met(op)) pc = pc + {{8{b[7]}}, b};
			end else if ((op & 8'hC7) == 8'hC6) alu(op[5:3], b);
			else if (op == OP_LDH_N_A) emit(1'b1, ebcpu_pkg::IO_PAGE | {8'h00, b}, rg[0]);
			else if (op == OP_LDH_A_N) begin
				read_at(ebcpu_pkg::IO_PAGE | {8'h00, b}, ebcpu_pkg::PH_MEM);
				return;
			end else if (op == OP_ADD_SP_E) sp = sp_offset(b);
			else if (op == OP_LD_HL_SP) set_pair(6, sp_offset(b));
			fetch();
		endfunction

		function void after_imm2(input logic [7:0] op, input logic [7:0] b);
			logic [15:0] nn;
			nn = {b, opr};
			if ((op & 8'hCF) == 8'h01) rr_set(op[5:4], nn);
			else if (op == OP_LD_NN_SP) begin
				emit(1'b1, nn, sp[7:0]);
				emit(1'b1, nn + 16'd1, sp[15:8]);
			end else if (op == 8'hC3 || ((op & 8'hE7) == 8'hC2 && cond_met(op))) pc = nn;
			else if (op == OP_CALL || ((op & 8'hE7) == 8'hC4 && cond_met(op))) begin
				push16(pc);
				pc = nn;
			end else if (op == 8'hEA) emit(1'b1, nn, rg[0]);
			else if (op == OP_LD_A_NN) begin
				read_at(nn, ebcpu_pkg::PH_MEM);
				return;
			end
			fetch();
		endfunction

		function void after_mem(input logic [7:0] op, input logic [7:0] b);
			if (op >= 8'h40 && op < 8'h80) store_reg(op[5:3], b);
			else if (op >= 8'h80 && op < 8'hC0) alu(op[5:3], b);
			else if (op == OP_INC_MHL) emit(1'b1, pair(6), inc8(b));
			else if (op == OP_DEC_MHL) emit(1'b1, pair(6), dec8(b));
			else begin
				rg[0] = b;
				if (op == OP_LDI_A) set_pair(6, pair(6) + 16'd1);
				if (op == 8'h3A) set_pair(6, pair(6) - 16'd1);
			end
			fetch();
		endfunction

		function void after_stack_high(input logic [7:0] op, input logic [7:0] b);
			logic [15:0] v;
			v = {b, opr};
			sp = sp + 16'd2;
			if (op == 8'hC1) set_pair(2, v);
			else if (op == 8'hD1) set_pair(4, v);
			else if (op == 8'hE1) set_pair(6, v);
			else if (op == OP_POP_AF) set_pair(0, v & 16'hFFF0);
			else begin
				pc = v;
				if (op == OP_RETI) ime = 1'b1;
			end
			fetch();
		endfunction

		function void note_item(input logic act, input logic [7:0] b, input logic [4:0] pend);
			logic [4:0] ack;
			int         n;
			bus_req_t   q;
			step_reqs.delete();
			ack = 5'd0;
			if (act) begin
				if (ph == ebcpu_pkg::PH_OP) fetch();
			end else begin
				case (ph)
					ebcpu_pkg::PH_OP: begin
						if (ime && pend != 5'd0) begin
							int i;
							i = 0;
							while (!pend[i]) i++;
							ack = 5'd1 << i;
							irqs_taken++;
							ime = 1'b0;
							hlt = 1'b0;
							push16(pc);
							pc = 16'(16'h40 + 8 * i);
							fetch();
						end else if (hlt && pend == 5'd0) fetch();
						else begin
							hlt = 1'b0;
							exec_opcode(b);
						end
					end
					ebcpu_pkg::PH_IM1: after_imm1(opl, b);
					ebcpu_pkg::PH_IM2: after_imm2(opl, b);
					ebcpu_pkg::PH_MEM: after_mem(opl, b);
					ebcpu_pkg::PH_SL: begin
						opr = b;
						read_at(sp + 16'd1, ebcpu_pkg::PH_SH);
					end
					ebcpu_pkg::PH_SH: after_stack_high(opl, b);
					default: ph = ebcpu_pkg::PH_OP;
				endcase
			end
			n = step_reqs.size();
			for (int k = 0; k < n; k++) begin
				q = step_reqs[k];
				q.ack = ack;
				q.halted = hlt;
				q.last = (k == n - 1);
				expected_reqs.push_back(q);
			end
		endfunction

		function void check_request(input bus_req_t got);
			bus_req_t w;
			if (expected_reqs.size() == 0) begin
				$error("unexpected bus request addr %h", got.addr);
				errors++;
				return;
			end
			w = expected_reqs.pop_front();
			reqs_checked++;
			if (got.wr !== w.wr) begin
				$error("bus_write: expected %h actual %h", w.wr, got.wr);
				errors++;
			end
			if (got.addr !== w.addr) begin
				$error("bus_address: expected %h actual %h", w.addr, got.addr);
				errors++;
			end
			if (got.data !== w.data) begin
				$error("write_data: expected %h actual %h", w.data, got.data);
				errors++;
			end
			if (got.ack !== w.ack) begin
				$error("int_ack: expected %h actual %h", w.ack, got.ack);
				errors++;
			end
			if (got.halted !== w.halted) begin
				$error("halted: expected %h actual %h", w.halted, got.halted);
				errors++;
			end
			if (got.last !== w.last) begin
				$error("last: expected %h actual %h", w.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	cpu_scoreboard sb = new();
	int send_idle_pct;
	int recv_stall_pct;
	int hold_left;
	int cycles = 0;
	int items_sent;

	eight_bit_cpu_execute_core_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	initial clk = 0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("eight_bit_cpu_execute_core_top_tb: errors");
			$finish;
		end
	end

	// receiver side
	always @(posedge clk) begin
		bus_req_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.wr = m_tuser;
			got.addr = m_tdata[15:0];
			got.data = m_tdata[23:16];
			got.ack = m_tdata[28:24];
			got.halted = m_tdata[29];
			got.last = m_tlast;
			sb.check_request(got);
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic send_item(input logic act, input logic [7:0] b, input logic [4:0] pend);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {3'b000, pend, b};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (act == ACT_DATA || sb.ph == ebcpu_pkg::PH_OP) items_sent++;
		sb.note_item(act, b, pend);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.expected_reqs.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		logic [7:0] favored[20];
		logic [7:0] b;
		logic [4:0] pend;
		favored = '{OP_NOP, OP_LD_NN_SP, OP_LD_A_N, OP_INC_MHL, OP_DEC_MHL, OP_LDI_A, OP_HALT,
			OP_PUSH_BC, OP_POP_AF, OP_ADD_A_N, OP_RET, OP_CALL, OP_RETI, OP_LDH_N_A,
			OP_ADD_SP_E, OP_LDH_A_N, OP_DI, OP_LD_HL_SP, OP_LD_A_NN, OP_EI};
		for (int n = 0; n < count; n++) begin
			b = 8'($urandom_range(255));
			if (sb.ph == ebcpu_pkg::PH_OP && $urandom_range(99) < 35)
				b = favored[$urandom_range(19)];
			pend = ($urandom_range(99) < 15) ? 5'($urandom_range(31)) : 5'd0;
			if ($urandom_range(99) < 5) send_item(ACT_START, b, pend);
			else send_item(ACT_DATA, b, pend);
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tuser <= 1'b0;
		s_tdata <= '0;
		m_tready <= 1'b0;
		arst_n <= 1'b0;
		items_sent = 0;
		hold_left = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: start, loads, alu flags, interrupts, halt, stack, word store
		send_item(ACT_START, 8'h00, 5'h00);
		send_item(ACT_DATA, OP_LD_A_N, 5'h00);
		send_item(ACT_START, 8'h00, 5'h00);
		send_item(ACT_DATA, 8'hFF, 5'h1F);
		send_item(ACT_DATA, OP_ADD_A_N, 5'h00);
		send_item(ACT_DATA, 8'h01, 5'h00);
		send_item(ACT_DATA, OP_EI, 5'h00);
		send_item(ACT_DATA, OP_NOP, 5'h1F);
		send_item(ACT_DATA, OP_EI, 5'h10);
		send_item(ACT_DATA, 8'h00, 5'h10);
		send_item(ACT_DATA, OP_HALT, 5'h00);
		send_item(ACT_DATA, 8'h00, 5'h00);
		send_item(ACT_DATA, OP_PUSH_BC, 5'h04);
		send_item(ACT_DATA, OP_POP_AF, 5'h00);
		send_item(ACT_DATA, 8'hFF, 5'h00);
		send_item(ACT_DATA, 8'hFF, 5'h00);
		send_item(ACT_DATA, OP_RETI, 5'h00);
		send_item(ACT_DATA, 8'h00, 5'h00);
		send_item(ACT_DATA, 8'h01, 5'h00);
		send_item(ACT_DATA, OP_LD_NN_SP, 5'h08);
		send_item(ACT_DATA, 8'h34, 5'h00);
		send_item(ACT_DATA, 8'h12, 5'h00);
		send_item(ACT_DATA, OP_RST38, 5'h02);
		wait_drained();

		for (int mode = 0; mode < 4; mode++) begin
			send_idle_pct = (mode == 1) ? 68 : ((mode == 3) ? 6 : 0);
			recv_stall_pct = (mode == 2) ? 68 : ((mode == 3) ? 6 : 0);
			send_random(20);
			wait_drained();
		end

		// receiver holds off while the sender keeps offering items
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_left = 300;
		send_random(20);
		wait_drained();

		if (sb.expected_reqs.size() != 0) begin
			$error("%0d bus requests never arrived", sb.expected_reqs.size());
			sb.errors++;
		end
		$display("ran %0d items, checked %0d bus requests, %0d interrupt entries",
			items_sent, sb.reqs_checked, sb.irqs_taken);
		if (sb.errors == 0)
			$display("eight_bit_cpu_execute_core_top_tb: clean");
		else
			$display("eight_bit_cpu_execute_core_top_tb: errors");
		$finish;
	end
endmodule
